// ===== src/gfd_pkg.sv =====
// ----------------------------------------------------------------------------
// gfd_pkg
// shared types, command codes and the decimal conversion step for the
// gauge frame to display command block
// ----------------------------------------------------------------------------
package gfd_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] CMD_CLEAR  = 8'h76;
  localparam logic [7:0] CMD_CURSOR = 8'h79;
  localparam logic [7:0] CMD_BRIGHT = 8'h7A;
  localparam logic [7:0] CMD_HOME   = 8'h00;
  localparam logic [7:0] CMD_RESET  = 8'hFF;
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  // bit positions of the pending flags
  localparam int PEND_RPM = 0;
  localparam int PEND_MPH = 1;
  localparam int PEND_CMD = 2;

  // item kinds on the input
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // display ports
  localparam logic PORT_ROAD   = 1'b0;
  localparam logic PORT_ENGINE = 1'b1;

  // one refresh burst, snapshot taken at the tick
  typedef struct packed {
    logic [2:0]  flags;
    logic [15:0] rpm;
    logic [15:0] mph;
    logic [7:0]  cmd;
  } job_t;

  // queue status towards both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // one shift-and-add-3 step: bits 35:16 hold five bcd digits, 15:0 the binary
  function automatic logic [35:0] dd_step(logic [35:0] x);
    logic [35:0] y;
    y = x;
    for (int i = 0; i < 5; i++) begin
      if (y[16 + 4*i +: 4] >= 4'd5) begin
        y[16 + 4*i +: 4] = y[16 + 4*i +: 4] + 4'd3;
      end
    end
    return {y[34:0], 1'b0};
  endfunction

endpackage

// ===== src/gfd_front.sv =====
// ----------------------------------------------------------------------------
// gfd_front
// frame decoder: tracks frame position, holds last values and pending flags,
// queues a refresh job on each tick with something pending
// ----------------------------------------------------------------------------
module gfd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic          s_tuser,
  input  gfd_pkg::q_stat_t q_stat,
  output logic          push,
  output gfd_pkg::job_t push_data
);
  import gfd_pkg::*;

  logic [2:0]  frame_pos;
  logic [7:0]  rpm_low_byte;
  logic [7:0]  mph_low_byte;
  logic [15:0] last_rpm;
  logic [15:0] last_mph;
  logic [7:0]  last_cmd;
  logic [2:0]  pending_flags;
  logic        accept;
  logic [15:0] new_val;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && (s_tuser == FUNC_TICK) && (pending_flags != 3'd0);

  assign push_data.flags = pending_flags;
  assign push_data.rpm   = last_rpm;
  assign push_data.mph   = last_mph;
  assign push_data.cmd   = last_cmd;

  always_comb begin
    new_val = (frame_pos == 3'd1) ? {s_tdata, rpm_low_byte} : {s_tdata, mph_low_byte};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos     <= 3'd0;
      rpm_low_byte  <= 8'd0;
      mph_low_byte  <= 8'd0;
      last_rpm      <= 16'd0;
      last_mph      <= 16'd0;
      last_cmd      <= CMD_RESET;
      pending_flags <= 3'd0;
    end else if (accept) begin
      if (s_tuser == FUNC_TICK) begin
        pending_flags <= 3'd0;
      end else if (s_tdata == SYNC_BYTE) begin
        frame_pos    <= 3'd0;
        rpm_low_byte <= 8'd0;
        mph_low_byte <= 8'd0;
      end else begin
        unique case (frame_pos)
          3'd0: begin
            rpm_low_byte <= s_tdata;
            frame_pos    <= 3'd1;
          end
          3'd1: begin
            if (new_val != last_rpm) begin
              last_rpm                <= new_val;
              pending_flags[PEND_RPM] <= 1'b1;
              rpm_low_byte            <= 8'd0;
            end
            frame_pos <= 3'd2;
          end
          3'd2: begin
            mph_low_byte <= s_tdata;
            frame_pos    <= 3'd3;
          end
          3'd3: begin
            if (new_val != last_mph) begin
              last_mph                <= new_val;
              pending_flags[PEND_MPH] <= 1'b1;
              mph_low_byte            <= 8'd0;
            end
            frame_pos <= 3'd4;
          end
          3'd4: begin
            if (s_tdata != last_cmd) begin
              last_cmd                <= s_tdata;
              pending_flags[PEND_CMD] <= 1'b1;
            end
            frame_pos <= 3'd5;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== src/gfd_queue.sv =====
// ----------------------------------------------------------------------------
// gfd_queue
// two-entry job queue between the decoder and the command sequencer
// ----------------------------------------------------------------------------
module gfd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gfd_pkg::job_t    push_data,
  input  logic             pop,
  output gfd_pkg::job_t    pop_data,
  output gfd_pkg::q_stat_t q_stat
);
  import gfd_pkg::*;

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign pop_data     = entry[rd_ptr];
  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/gfd_back.sv =====
// ----------------------------------------------------------------------------
// gfd_back
// command sequencer: converts both values to decimal, then plays out the
// display command bytes through an output register
// ----------------------------------------------------------------------------
module gfd_back (
  input  logic             clk,
  input  logic             rst,
  input  gfd_pkg::q_stat_t q_stat,
  input  gfd_pkg::job_t    pop_data,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tuser,
  output logic             m_tlast
);
  import gfd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [1:0] SEG_RPM = 2'd0;
  localparam logic [1:0] SEG_MPH = 2'd1;
  localparam logic [1:0] SEG_CMD = 2'd2;

  logic [1:0]  state;
  logic [2:0]  conv_cnt;
  logic [1:0]  seg;
  logic [3:0]  step;
  job_t        job;
  logic [35:0] rpm_dd;
  logic [35:0] mph_dd;

  logic        can_load;
  logic [15:0] val;
  logic [15:0] bcd;
  logic [2:0]  count;
  logic [3:0]  count_w;
  logic [1:0]  pos;
  logic [1:0]  digit_idx;
  logic [3:0]  digit_off;
  logic [7:0]  byte_val;
  logic        port_val;
  logic        seg_end;
  logic        has_next;
  logic [1:0]  next_seg;
  logic [1:0]  first_seg;

  assign can_load = !m_tvalid || m_tready;
  assign pop      = (state == ST_IDLE) && !q_stat.empty;

  always_comb begin
    priority if (pop_data.flags[PEND_RPM]) first_seg = SEG_RPM;
    else if (pop_data.flags[PEND_MPH])     first_seg = SEG_MPH;
    else                                    first_seg = SEG_CMD;
  end

  always_comb begin
    val = (seg == SEG_RPM) ? job.rpm : job.mph;
    bcd = (seg == SEG_RPM) ? rpm_dd[31:16] : mph_dd[31:16];
    priority if (val >= 16'd1000) count = 3'd4;
    else if (val >= 16'd100)      count = 3'd3;
    else if (val >= 16'd10)       count = 3'd2;
    else                          count = 3'd1;
    count_w   = {1'b0, count};
    pos       = 2'(3'd4 - count);
    digit_off = count_w + 4'd2 - step;
    digit_idx = digit_off[1:0];

    if (seg == SEG_CMD) begin
      byte_val = step[0] ? job.cmd : CMD_BRIGHT;
      port_val = (step < 4'd2) ? PORT_ENGINE : PORT_ROAD;
      seg_end  = (step == 4'd3);
    end else begin
      port_val = (seg == SEG_RPM) ? PORT_ENGINE : PORT_ROAD;
      seg_end  = (step == count_w + 4'd4);
      priority if (step == 4'd0)       byte_val = CMD_CLEAR;
      else if (step == 4'd1)           byte_val = CMD_CURSOR;
      else if (step == 4'd2)           byte_val = {6'd0, pos};
      else if (step < count_w + 4'd3)  byte_val = {4'd0, bcd[4*digit_idx +: 4] & NIBBLE_MASK};
      else if (step == count_w + 4'd3) byte_val = CMD_CURSOR;
      else                             byte_val = CMD_HOME;
    end

    unique case (seg)
      SEG_RPM: begin
        has_next = job.flags[PEND_MPH] || job.flags[PEND_CMD];
        next_seg = job.flags[PEND_MPH] ? SEG_MPH : SEG_CMD;
      end
      SEG_MPH: begin
        has_next = job.flags[PEND_CMD];
        next_seg = SEG_CMD;
      end
      default: begin
        has_next = 1'b0;
        next_seg = SEG_CMD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job    <= pop_data;
      rpm_dd <= {20'd0, pop_data.rpm};
      mph_dd <= {20'd0, pop_data.mph};
    end else if (state == ST_CONV) begin
      rpm_dd <= dd_step(dd_step(rpm_dd));
      mph_dd <= dd_step(dd_step(mph_dd));
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && can_load) begin
      m_tdata <= byte_val;
      m_tuser <= port_val;
      m_tlast <= seg_end && !has_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      conv_cnt <= 3'd0;
      seg      <= SEG_RPM;
      step     <= 4'd0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_EMIT) && can_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            state    <= ST_CONV;
            conv_cnt <= 3'd0;
            seg      <= first_seg;
            step     <= 4'd0;
          end
        end
        ST_CONV: begin
          conv_cnt <= conv_cnt + 3'd1;
          if (conv_cnt == 3'd7) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (can_load) begin
            if (seg_end) begin
              step <= 4'd0;
              if (has_next) begin
                seg <= next_seg;
              end else begin
                state <= ST_IDLE;
              end
            end else begin
              step <= step + 4'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/gauge_frame_to_display_commands.sv =====
// ----------------------------------------------------------------------------
// gauge_frame_to_display_commands
// decodes gauge frames from received bytes and, on refresh ticks, sends
// seven-segment command bursts to the engine and road speed displays
// ----------------------------------------------------------------------------
//  channel | dir | tdata             | tuser               | tlast
//  s_*     | in  | rx_byte [7:0]     | func (0 byte, 1 tick)| -
//  m_*     | out | data_byte [7:0]   | port (0 road, 1 eng) | last of burst
//
//  bytes are taken one per cycle while the job queue has room and never produce output
//  a tick with something pending is taken like a byte and queues a job;
//  the sequencer then loads the job, runs the decimal conversion (two bits
//  a cycle) and plays out the command bytes, up to 22
//  s_tready drops only while both job queue slots are full; m_tready stalls
//  hold the output register and the sequencer, not the decoder
//  synchronous active-high reset clears frame state, pending flags and queue
// ----------------------------------------------------------------------------
module gauge_frame_to_display_commands (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // rx_byte [7:0]
  input  logic       s_tuser,   // func [0]
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // data_byte [7:0]
  output logic       m_tuser,   // port [0]
  output logic       m_tlast
);
  import gfd_pkg::*;

  // front to queue
  logic    push;
  job_t    push_data;
  // queue to back
  logic    pop;
  job_t    pop_data;
  q_stat_t q_stat;

  // frame decoder and pending tracking
  gfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // snapshot of the values at each tick, so later frames cannot disturb a burst
  gfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // decimal conversion and byte sequencing
  gfd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  // a job is never written into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("job pushed into full queue");

  // the sequencer only takes a job that is there
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("job popped from empty queue");

  // a queued job with nothing to send would still play out the brightness commands
  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_data.flags != 3'd0))
    else $error("empty job queued");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule

// ===== dv/gauge_frame_to_display_commands_tb.sv =====
// ----------------------------------------------------------------------------
// gauge_frame_to_display_commands_tb
// self-checking bench: drives gauge frames and refresh ticks into the block,
// predicts every display byte of each tick burst and checks the output
// stream item by item, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module gauge_frame_to_display_commands_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gfd_pkg::*;

  // one expected display byte
  typedef struct packed {
    logic       port;
    logic [7:0] data;
    logic       last;
  } tx_byte_t;

  localparam int ITEM_TARGET  = 460;
  localparam int TAIL_CYCLES  = 64;     // well over one burst of 22 bytes plus conversion
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int MAX_GAUGE    = 16'hFEFE; // largest value a frame can carry without a sync byte

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;     // rx_byte [7:0]
  logic       s_tuser = FUNC_BYTE; // func [0]
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;             // data_byte [7:0]
  logic       m_tuser;             // port [0]
  logic       m_tlast;             // last byte of the burst

  gauge_frame_to_display_commands uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // bench copy of the frame decoder state
  logic [2:0]  fr_pos;
  logic [7:0]  rpm_lo_held;
  logic [7:0]  mph_lo_held;
  logic [15:0] shown_rpm;
  logic [15:0] shown_mph;
  logic [7:0]  shown_cmd;
  logic [2:0]  pend;

  tx_byte_t display_bytes_due[$];  // bytes still owed by the block, oldest first
  tx_byte_t tick_burst[$];         // burst being assembled for one tick
  tx_byte_t due_head;

  int  error_count  = 0;
  int  items_sent   = 0;
  bit  send_gaps_on = 1'b1;
  bit  recv_gaps_on = 1'b1;
  int  hold_req     = 0;           // set by a test, taken up by the receiver

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("mismatch at %0t: %s, wanted %0h, got %0h", $time, what, want, got);
    error_count++;
  endtask

  task automatic add_tx_byte(input logic port, input logic [7:0] data);
    tx_byte_t b;
    b.port = port;
    b.data = data;
    b.last = 1'b0;
    tick_burst.push_back(b);
  endtask

  // clear, cursor to right-aligned position, digits msd first, cursor home
  task automatic add_gauge_digits(input logic [15:0] val, input logic port);
    int rest;
    int pos;
    int cnt;
    int dig [4];
    rest = val % 10000;
    for (int i = 0; i < 4; i++) begin
      dig[i] = rest % 10;
      rest = rest / 10;
    end
    // the position follows the full value, the digits only val mod 10000
    if (val >= 1000) begin
      pos = 0; cnt = 4;
    end else if (val >= 100) begin
      pos = 1; cnt = 3;
    end else if (val >= 10) begin
      pos = 2; cnt = 2;
    end else begin
      pos = 3; cnt = 1;
    end
    add_tx_byte(port, CMD_CLEAR);
    add_tx_byte(port, CMD_CURSOR);
    add_tx_byte(port, 8'(pos));
    for (int i = cnt; i > 0; i--) add_tx_byte(port, 8'(dig[i-1]));
    add_tx_byte(port, CMD_CURSOR);
    add_tx_byte(port, CMD_HOME);
  endtask

  // frame decoding and tick burst prediction for one accepted item
  task automatic predict_display_bytes(input logic func, input logic [7:0] b);
    logic [15:0] v;
    tx_byte_t    t;
    if (func == FUNC_BYTE) begin
      if (b == SYNC_BYTE) begin
        fr_pos = 3'd0;
        rpm_lo_held = 8'h00;
        mph_lo_held = 8'h00;
      end else begin
        case (fr_pos)
          3'd0: begin
            rpm_lo_held = b;
            fr_pos = 3'd1;
          end
          3'd1: begin
            v = {b, rpm_lo_held};
            if (v != shown_rpm) begin
              shown_rpm = v;
              pend[PEND_RPM] = 1'b1;
              rpm_lo_held = 8'h00;
            end
            fr_pos = 3'd2;
          end
          3'd2: begin
            mph_lo_held = b;
            fr_pos = 3'd3;
          end
          3'd3: begin
            v = {b, mph_lo_held};
            if (v != shown_mph) begin
              shown_mph = v;
              pend[PEND_MPH] = 1'b1;
              mph_lo_held = 8'h00;
            end
            fr_pos = 3'd4;
          end
          3'd4: begin
            if (b != shown_cmd) begin
              shown_cmd = b;
              pend[PEND_CMD] = 1'b1;
            end
            fr_pos = 3'd5;
          end
          default: ; // past the frame, wait for the next sync
        endcase
      end
    end else begin
      tick_burst.delete();
      if (pend[PEND_RPM]) add_gauge_digits(shown_rpm, PORT_ENGINE);
      if (pend[PEND_MPH]) add_gauge_digits(shown_mph, PORT_ROAD);
      if (pend[PEND_CMD]) begin
        add_tx_byte(PORT_ENGINE, CMD_BRIGHT);
        add_tx_byte(PORT_ENGINE, shown_cmd);
        add_tx_byte(PORT_ROAD, CMD_BRIGHT);
        add_tx_byte(PORT_ROAD, shown_cmd);
      end
      pend = 3'b000;
      foreach (tick_burst[i]) begin
        t = tick_burst[i];
        t.last = (i == tick_burst.size() - 1);
        display_bytes_due.push_back(t);
      end
    end
  endtask

  // offer one item after a random gap, hold it until accepted
  task automatic send_item(input logic func, input logic [7:0] b);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_display_bytes(func, b);
    items_sent++;
  endtask

  // tick carries junk in the data lane, the block ignores it
  task automatic send_tick();
    send_item(FUNC_TICK, 8'($urandom));
  endtask

  task automatic send_frame(input logic [15:0] rpm, input logic [15:0] mph,
                            input logic [7:0] cmd);
    send_item(FUNC_BYTE, SYNC_BYTE);
    send_item(FUNC_BYTE, rpm[7:0]);
    send_item(FUNC_BYTE, rpm[15:8]);
    send_item(FUNC_BYTE, mph[7:0]);
    send_item(FUNC_BYTE, mph[15:8]);
    send_item(FUNC_BYTE, cmd);
  endtask

  // sender stays quiet until every owed byte has come, then lets the block settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (display_bytes_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // gauge value spread over all digit-count bands, no byte may be a sync
  function automatic logic [15:0] pick_gauge_value();
    logic [15:0] v;
    int edges [10] = '{0, 9, 10, 99, 100, 999, 1000, 9999, 10000, MAX_GAUGE};
    case ($urandom_range(0, 5))
      0: v = 16'($urandom_range(0, 9));
      1: v = 16'($urandom_range(10, 99));
      2: v = 16'($urandom_range(100, 999));
      3: v = 16'($urandom_range(1000, 9999));
      4: v = 16'($urandom_range(10000, MAX_GAUGE));
      default: v = 16'(edges[$urandom_range(0, 9)]);
    endcase
    if (v[7:0] == SYNC_BYTE) v[7:0] = 8'hFE;
    if (v[15:8] == SYNC_BYTE) v[15:8] = 8'hFE;
    return v;
  endfunction

  // tick straight out of reset: nothing pending, nothing sent
  task automatic test_idle_tick();
    send_tick();
    wait_drained();
  endtask

  // largest value, single digit, the 1000 and 999 boundaries, both command extremes
  task automatic test_digit_ranges();
    send_frame(16'(MAX_GAUGE), 16'd5, 8'h00);
    send_tick();
    send_frame(16'd1000, 16'd999, 8'hFE);
    send_tick();
    wait_drained();
  endtask

  // repeated values stay quiet, a byte past the frame is dropped, a short frame resyncs
  task automatic test_unchanged_and_overrun();
    send_frame(16'd1000, 16'd10, 8'hFE);
    send_item(FUNC_BYTE, 8'h55);
    send_tick();
    send_item(FUNC_BYTE, SYNC_BYTE);
    send_item(FUNC_BYTE, 8'h34);
    wait_drained();
  endtask

  // receiver holds off while full bursts keep coming, the job queue fills and
  // the input must stall
  task automatic test_output_backpressure();
    send_gaps_on = 1'b0;
    hold_req = HOLD_CYCLES;
    for (int r = 0; r < 8; r++) begin
      send_frame(16'(2000 + 37 * r), 16'(20 + r), 8'(r));
      send_tick();
    end
    send_gaps_on = 1'b1;
    wait_drained();
  endtask

  // mostly well-formed frames with random content, the rest noise and broken frames
  task automatic test_random_traffic();
    logic [15:0] rpm;
    logic [15:0] mph;
    logic [7:0]  cmd;
    int          kind;
    int          n;
    while (items_sent < ITEM_TARGET) begin
      // stretches with and without idling on either side
      if ($urandom_range(0, 9) == 0) begin
        send_gaps_on = ($urandom_range(0, 3) != 0);
        recv_gaps_on = ($urandom_range(0, 3) != 0);
      end
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        rpm = ($urandom_range(0, 3) == 0) ? shown_rpm : pick_gauge_value();
        mph = ($urandom_range(0, 3) == 0) ? shown_mph : pick_gauge_value();
        cmd = ($urandom_range(0, 3) == 0) ? shown_cmd : 8'($urandom_range(0, 254));
        if (cmd == SYNC_BYTE) cmd = 8'h00;
        send_frame(rpm, mph, cmd);
        if ($urandom_range(0, 9) < 7) send_tick();
      end else if (kind < 15) begin
        // frame cut short, later bytes may even be a sync
        send_item(FUNC_BYTE, SYNC_BYTE);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) send_item(FUNC_BYTE, 8'($urandom_range(0, 255)));
      end else if (kind < 17) begin
        // raw noise, includes bytes landing past the frame
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 7) == 0) send_item(FUNC_BYTE, SYNC_BYTE);
          else send_item(FUNC_BYTE, 8'($urandom));
        end
      end else begin
        send_tick();
      end
      if ($urandom_range(0, 24) == 0) wait_drained();
    end
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
  endtask

  // receiver: random stall before each item, plus the long hold-off on request
  initial begin : receiver
    int gap;
    int hold_left;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        m_tready <= 1'b0;
        hold_left = hold_req;
        hold_req = 0;
        repeat (hold_left) @(posedge clk);
      end
      gap = recv_gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid && hold_req == 0) @(posedge clk);
    end
  end

  // output checker, oldest owed byte first
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (display_bytes_due.size() == 0) begin
        report_mismatch("item with nothing owed, data", 0, m_tdata);
      end else begin
        due_head = display_bytes_due.pop_front();
        if (m_tuser !== due_head.port) report_mismatch("port", due_head.port, m_tuser);
        if (m_tdata !== due_head.data) report_mismatch("data_byte", due_head.data, m_tdata);
        if (m_tlast !== due_head.last) report_mismatch("last", due_head.last, m_tlast);
      end
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    // reset state of the bench copy
    fr_pos      = 3'd0;
    rpm_lo_held = 8'h00;
    mph_lo_held = 8'h00;
    shown_rpm   = 16'h0000;
    shown_mph   = 16'h0000;
    shown_cmd   = 8'hFF;
    pend        = 3'b000;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_idle_tick();
    test_digit_ranges();
    test_unchanged_and_overrun();
    test_output_backpressure();
    test_random_traffic();

    wait_drained();
    if (display_bytes_due.size() != 0)
      report_mismatch("bytes never sent", display_bytes_due.size(), 0);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/gfd_pkg.sv
src/gfd_front.sv
src/gfd_queue.sv
src/gfd_back.sv
src/gauge_frame_to_display_commands.sv
dv/gauge_frame_to_display_commands_tb.sv
